// File: src/yuv420_pixel_pair_to_uyvy_or_rgb_unit_assert.svh
// assertion macros for the pixel pair converter
// used by the top level only, no other dependencies
`ifndef YUV420_PIXEL_PAIR_TO_UYVY_OR_RGB_UNIT_ASSERT_SVH
`define YUV420_PIXEL_PAIR_TO_UYVY_OR_RGB_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// consequence must hold in the cycle after the antecedent
`define YUVPP_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yuvpp check failed");
// consequence must hold in the same cycle as the antecedent
`define YUVPP_CHECK_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yuvpp check failed");
`else
`define YUVPP_CHECK_NEXT(lbl, clk, rst_n, ante, cons)
`define YUVPP_CHECK_NOW(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/yuvpp_pkg.sv
// shared types and constants for the pixel pair converter
// no dependencies
package yuvpp_pkg;

    // q16 coefficients, rounded to nearest
    localparam logic signed [17:0] COEF_RV = 18'sd91881;
    localparam logic signed [17:0] COEF_GU = 18'sd22554;
    localparam logic signed [17:0] COEF_GV = 18'sd46802;
    localparam logic signed [17:0] COEF_BU = 18'sd116130;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // output mode codes
    localparam logic MODE_UYVY = 1'b0;
    localparam logic MODE_RGB  = 1'b1;

    // q16 chroma contribution, |value| below 2^24
    typedef logic signed [25:0] t_term;

    // chroma contributions shared by both pixels of a pair
    typedef struct packed {
        t_term rv;
        t_term gn;
        t_term bu;
    } t_chroma;

    // one clamped rgb pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

// File: src/yuvpp_chroma.sv
// chroma multipliers: q16 contributions of u and v to r, g and b
// depends on yuvpp_pkg
module yuvpp_chroma (
    input  logic [7:0]        i_chroma_blue,
    input  logic [7:0]        i_chroma_red,
    output yuvpp_pkg::t_chroma o_chroma
);

    logic signed [7:0] w_du;
    logic signed [7:0] w_dv;
    yuvpp_pkg::t_term  w_gu;
    yuvpp_pkg::t_term  w_gv;

    // remove the 128 offset: flipping the top bit gives x - 128
    assign w_du = $signed({~i_chroma_blue[7], i_chroma_blue[6:0]});
    assign w_dv = $signed({~i_chroma_red[7], i_chroma_red[6:0]});

    // constant multiplications
    assign o_chroma.rv = 26'(w_dv) * 26'(yuvpp_pkg::COEF_RV);
    assign w_gu        = 26'(w_du) * 26'(yuvpp_pkg::COEF_GU);
    assign w_gv        = 26'(w_dv) * 26'(yuvpp_pkg::COEF_GV);
    assign o_chroma.gn = -(w_gu + w_gv);
    assign o_chroma.bu = 26'(w_du) * 26'(yuvpp_pkg::COEF_BU);

endmodule

// File: src/yuvpp_lane.sv
// one pixel lane: adds luma to the chroma terms, floors and clamps
// depends on yuvpp_pkg
module yuvpp_lane (
    input  logic [7:0]         i_luma,
    input  yuvpp_pkg::t_chroma i_chroma,
    output yuvpp_pkg::t_rgb    o_rgb
);

    logic signed [26:0] w_base;
    logic signed [26:0] w_acc_r;
    logic signed [26:0] w_acc_g;
    logic signed [26:0] w_acc_b;

    function automatic logic [7:0] clamp_q16(input logic signed [26:0] acc);
        logic [7:0] res;
        // negative gives 0, above 255 gives 255, else the floored integer part
        priority if (acc[26]) begin
            res = 8'd0;
        end else if (acc[25:24] != 2'b00) begin
            res = yuvpp_pkg::CHAN_MAX;
        end else begin
            res = acc[23:16];
        end
        return res;
    endfunction

    // luma in q16
    assign w_base  = $signed({3'b000, i_luma, 16'h0000});
    assign w_acc_r = w_base + 27'(i_chroma.rv);
    assign w_acc_g = w_base + 27'(i_chroma.gn);
    assign w_acc_b = w_base + 27'(i_chroma.bu);

    // per channel clamp
    assign o_rgb.red   = clamp_q16(w_acc_r);
    assign o_rgb.green = clamp_q16(w_acc_g);
    assign o_rgb.blue  = clamp_q16(w_acc_b);

endmodule

// File: src/yuv420_pixel_pair_to_uyvy_or_rgb_unit.sv
// Pixel pair converter, 4:2:0 planar pair to UYVY word or two RGB pixels.
// Depends on yuvpp_pkg, yuvpp_chroma, yuvpp_lane and the assertion header.
//
// Input channel: i_in_valid / o_in_ready carry one pixel pair per
// transaction (two luma samples and the shared U and V).
// Output channel: o_out_valid / i_out_ready carry one result per transaction.
// Mode register: i_cfg_we writes i_cfg_wdata into the output mode at the
// clock edge; 0 packs UYVY (U, Y0, V, Y1 from the low byte), 1 converts both
// pixels to RGB. Fields of the mode not selected read as zero. Write the mode
// only when no transaction is in flight.
//
// The chroma products are registered in the first stage, then two lanes
// finish both pixels and the merge stage loads the output register.
// Throughput is one pair per cycle; the pipeline of two registered stages
// advances whenever the output register is empty or taken.
// When the receiver stalls, the result holds and one more pair can wait in
// the first stage before o_in_ready falls.
// Reset (synchronous, active low) empties the pipeline and sets mode 0.
module yuv420_pixel_pair_to_uyvy_or_rgb_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_luma_first,
    input  logic [7:0]  i_luma_second,
    input  logic [7:0]  i_chroma_blue,
    input  logic [7:0]  i_chroma_red,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_packed_word,
    output logic [7:0]  o_red_first,
    output logic [7:0]  o_green_first,
    output logic [7:0]  o_blue_first,
    output logic [7:0]  o_red_second,
    output logic [7:0]  o_green_second,
    output logic [7:0]  o_blue_second
);

    logic r_mode;

    logic               r_s1_valid;
    logic [7:0]         r_s1_y0;
    logic [7:0]         r_s1_y1;
    logic [7:0]         r_s1_u;
    logic [7:0]         r_s1_v;
    yuvpp_pkg::t_chroma r_s1_chroma;

    logic        r_o_valid;
    logic [31:0] r_o_packed;
    yuvpp_pkg::t_rgb r_o_rgb0;
    yuvpp_pkg::t_rgb r_o_rgb1;

    yuvpp_pkg::t_chroma w_chroma;
    yuvpp_pkg::t_rgb    w_rgb0;
    yuvpp_pkg::t_rgb    w_rgb1;
    logic [31:0]        n_o_packed;
    yuvpp_pkg::t_rgb    n_o_rgb0;
    yuvpp_pkg::t_rgb    n_o_rgb1;
    logic               w_out_load;
    logic               w_s1_load;

    // pipeline flow control
    assign w_out_load = !r_o_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_out_load;
    assign w_s1_load  = i_in_valid && o_in_ready;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= yuvpp_pkg::MODE_UYVY;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // shared chroma products
    yuvpp_chroma u_chroma (
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_chroma      (w_chroma)
    );

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_y0     <= i_luma_first;
            r_s1_y1     <= i_luma_second;
            r_s1_u      <= i_chroma_blue;
            r_s1_v      <= i_chroma_red;
            r_s1_chroma <= w_chroma;
        end
    end

    // pixel lanes, one per luma sample
    yuvpp_lane u_lane_first (
        .i_luma   (r_s1_y0),
        .i_chroma (r_s1_chroma),
        .o_rgb    (w_rgb0)
    );

    yuvpp_lane u_lane_second (
        .i_luma   (r_s1_y1),
        .i_chroma (r_s1_chroma),
        .o_rgb    (w_rgb1)
    );

    // merge: packed word or lane results, the other fields zero
    always_comb begin
        unique case (r_mode)
            yuvpp_pkg::MODE_RGB: begin
                n_o_packed = 32'h0000_0000;
                n_o_rgb0   = w_rgb0;
                n_o_rgb1   = w_rgb1;
            end
            default: begin
                n_o_packed = {r_s1_y1, r_s1_v, r_s1_y0, r_s1_u};
                n_o_rgb0   = '0;
                n_o_rgb1   = '0;
            end
        endcase
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= r_s1_valid;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_o_packed <= n_o_packed;
            r_o_rgb0   <= n_o_rgb0;
            r_o_rgb1   <= n_o_rgb1;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_packed_word  = r_o_packed;
    assign o_red_first    = r_o_rgb0.red;
    assign o_green_first  = r_o_rgb0.green;
    assign o_blue_first   = r_o_rgb0.blue;
    assign o_red_second   = r_o_rgb1.red;
    assign o_green_second = r_o_rgb1.green;
    assign o_blue_second  = r_o_rgb1.blue;

    // checks
`include "yuv420_pixel_pair_to_uyvy_or_rgb_unit_assert.svh"

    `YUVPP_CHECK_NEXT(a_accept_fills_s1, i_clk, i_rst_n, w_s1_load, r_s1_valid)
    `YUVPP_CHECK_NEXT(a_s1_moves_out, i_clk, i_rst_n, r_s1_valid && w_out_load, r_o_valid)
    `YUVPP_CHECK_NOW(a_modes_exclusive, i_clk, i_rst_n,
        o_out_valid && (o_packed_word != 32'h0),
        (r_o_rgb0 == '0) && (r_o_rgb1 == '0))

endmodule

// File: tb/yuv420_pixel_pair_to_uyvy_or_rgb_unit_tb.sv
// self-checking testbench for the pixel pair converter: uyvy packing and rgb conversion
// predicts every result in fixed point and compares it field by field on the output channel
// depends on yuvpp_pkg and the yuv420_pixel_pair_to_uyvy_or_rgb_unit top level
module yuv420_pixel_pair_to_uyvy_or_rgb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // q16 coefficients of the full-range conversion
    localparam longint Q16_RED_V   = 91881;
    localparam longint Q16_GREEN_U = 22554;
    localparam longint Q16_GREEN_V = 46802;
    localparam longint Q16_BLUE_U  = 116130;
    localparam longint CHROMA_BIAS = 128;

    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0]     word;
        yuvpp_pkg::t_rgb first;
        yuvpp_pkg::t_rgb second;
    } t_pair_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_luma_first   = 8'd0;
    logic [7:0]  i_luma_second  = 8'd0;
    logic [7:0]  i_chroma_blue  = 8'd0;
    logic [7:0]  i_chroma_red   = 8'd0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_packed_word;
    logic [7:0]  o_red_first;
    logic [7:0]  o_green_first;
    logic [7:0]  o_blue_first;
    logic [7:0]  o_red_second;
    logic [7:0]  o_green_second;
    logic [7:0]  o_blue_second;

    // expected results in order, plus the mode the block holds
    t_pair_result pending_results[$];
    logic         output_mode    = yuvpp_pkg::MODE_UYVY;
    bit           gaps_on        = 1'b1;
    int           pairs_sent     = 0;
    int           pairs_packed   = 0;
    int           pairs_rgb      = 0;
    int           results_seen   = 0;
    int           failures       = 0;
    int           quiet_cycles   = 0;

    yuv420_pixel_pair_to_uyvy_or_rgb_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packed_word  (o_packed_word),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // floor a q16 value to an integer, then saturate to one byte
    function automatic logic [7:0] saturate_q16(input longint acc);
        longint whole;
        whole = acc >>> 16;
        if (whole < 0) return 8'd0;
        if (whole > 255) return 8'd255;
        return whole[7:0];
    endfunction

    // one pixel to rgb from its luma and the shared chroma offsets
    function automatic yuvpp_pkg::t_rgb pixel_to_rgb(input logic [7:0] luma, input longint du,
                                                     input longint dv);
        yuvpp_pkg::t_rgb px;
        longint          base;
        base = luma;
        base = base * 65536;
        px.red   = saturate_q16(base + Q16_RED_V * dv);
        px.green = saturate_q16(base - Q16_GREEN_U * du - Q16_GREEN_V * dv);
        px.blue  = saturate_q16(base + Q16_BLUE_U * du);
        return px;
    endfunction

    // expected result of one pixel pair in the given mode
    function automatic t_pair_result convert_pair(input logic mode, input logic [7:0] y0,
                                                  input logic [7:0] y1, input logic [7:0] u,
                                                  input logic [7:0] v);
        t_pair_result res;
        longint       du;
        longint       dv;
        res = '0;
        du  = u;
        dv  = v;
        du  = du - CHROMA_BIAS;
        dv  = dv - CHROMA_BIAS;
        if (mode == yuvpp_pkg::MODE_UYVY) begin
            res.word = {y1, v, y0, u};
        end else begin
            res.first  = pixel_to_rgb(y0, du, dv);
            res.second = pixel_to_rgb(y1, du, dv);
        end
        return res;
    endfunction

    // sample biased towards the ends and the middle of the range
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(4))
            0: return 8'($urandom_range(15));
            1: return 8'(240 + $urandom_range(15));
            2: return 8'(112 + $urandom_range(31));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // offer one pixel pair, optionally after idle cycles, and log its expected result
    task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1,
                             input logic [7:0] u, input logic [7:0] v);
        while (gaps_on && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_luma_first  <= y0;
        i_luma_second <= y1;
        i_chroma_blue <= u;
        i_chroma_red  <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(convert_pair(output_mode, y0, y1, u, v));
        pairs_sent++;
        if (output_mode == yuvpp_pkg::MODE_UYVY) pairs_packed++;
        else pairs_rgb++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // mode changes only with the pipeline empty
    task automatic write_output_mode(input logic mode);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        output_mode = mode;
    endtask

    // mode after reset must be uyvy packing, no write yet
    task automatic test_reset_default_mode();
        send_pair(8'h00, 8'h00, 8'h00, 8'h00);
        send_pair(8'hff, 8'hff, 8'hff, 8'hff);
        send_pair(8'h12, 8'h34, 8'h56, 8'h78);
    endtask

    // byte placement in the packed word, alternating bit patterns
    task automatic test_uyvy_bit_patterns();
        write_output_mode(yuvpp_pkg::MODE_UYVY);
        send_pair(8'h55, 8'haa, 8'h55, 8'haa);
        send_pair(8'haa, 8'h55, 8'haa, 8'h55);
        send_pair(8'h01, 8'h80, 8'hfe, 8'h7f);
    endtask

    // black, white, saturation both ways, neutral grey and rounding near the edges
    task automatic test_rgb_extremes();
        write_output_mode(yuvpp_pkg::MODE_RGB);
        send_pair(8'h00, 8'hff, 8'h80, 8'h80);
        send_pair(8'h00, 8'hff, 8'h00, 8'h00);
        send_pair(8'h00, 8'hff, 8'hff, 8'hff);
        send_pair(8'h00, 8'hff, 8'h00, 8'hff);
        send_pair(8'h00, 8'hff, 8'hff, 8'h00);
        send_pair(8'h80, 8'h80, 8'h80, 8'h80);
        send_pair(8'd16, 8'd235, 8'd16, 8'd240);
        send_pair(8'h01, 8'hfe, 8'h7f, 8'h81);
        send_pair(8'd100, 8'd200, 8'd90, 8'd170);
        send_pair(8'hff, 8'h00, 8'h01, 8'hfe);
        send_pair(8'h00, 8'h00, 8'h81, 8'h7f);
    endtask

    // random pairs in one mode, with or without idle cycles on both sides
    task automatic test_random_traffic(input logic mode, input int count, input bit with_gaps);
        gaps_on = with_gaps;
        write_output_mode(mode);
        repeat (count) send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // sender holds off mid-stream until every result has been delivered
    task automatic test_drain_pause();
        gaps_on = 1'b1;
        write_output_mode(yuvpp_pkg::MODE_RGB);
        repeat (50) send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        drain_results();
        repeat (50) send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // receiver stalls, result check and watchdog
    always @(posedge i_clk) begin : result_check
        t_pair_result got;
        t_pair_result want;
        i_out_ready <= !(gaps_on && $urandom_range(99) < 17);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_packed_word, o_red_first, o_green_first, o_blue_first,
                   o_red_second, o_green_second, o_blue_second};
            results_seen++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: word=%h rgb0=%h rgb1=%h",
                             got.word, got.first, got.second);
            end else begin
                want = pending_results.pop_front();
                if (got.word !== want.word || got.first !== want.first ||
                    got.second !== want.second) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display({"result %0d mismatch: exp word=%h rgb0=%h rgb1=%h,",
                                  " got word=%h rgb0=%h rgb1=%h"},
                                 results_seen, want.word, want.first, want.second,
                                 got.word, got.first, got.second);
                end
            end
        end
        // count cycles without any transaction
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("yuv420_pixel_pair_to_uyvy_or_rgb_unit_tb NOT OK");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_default_mode();
        test_uyvy_bit_patterns();
        test_rgb_extremes();
        test_random_traffic(yuvpp_pkg::MODE_RGB, 400, 1'b1);
        test_random_traffic(yuvpp_pkg::MODE_UYVY, 250, 1'b1);
        test_random_traffic(yuvpp_pkg::MODE_RGB, 350, 1'b0);
        test_drain_pause();
        test_random_traffic(yuvpp_pkg::MODE_UYVY, 150, 1'b0);
        test_random_traffic(yuvpp_pkg::MODE_RGB, 300, 1'b1);
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("sent %0d pixel pairs: %0d packed as uyvy, %0d converted to rgb",
                 pairs_sent, pairs_packed, pairs_rgb);
        $display("checked %0d results across mode changes and stalls, %0d failures",
                 results_seen, failures);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("yuv420_pixel_pair_to_uyvy_or_rgb_unit_tb OK");
        end else begin
            $display("yuv420_pixel_pair_to_uyvy_or_rgb_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
